FILE: rtl/core/nmpv_pkg.sv
package nmpv_pkg;

  localparam int MaxPartitionsDef = 16;
  localparam int CountBitsDef     = 16;

  localparam int VidW  = 32;
  localparam int PartW = 4;
  localparam int PiuW  = 5;

  localparam logic [PiuW-1:0] PiuReset = 5'd16;

  // apb register map
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;
  localparam logic RegIdxPiu = 1'b0;

  typedef struct packed {
    logic [VidW-1:0]  vtx_id;
    logic [PartW-1:0] own_partition;
    logic [PartW-1:0] neighbor_partition;
    logic             has_neighbor;
    logic             last_of_vertex;
  } in_item_t;

  typedef struct packed {
    logic [VidW-1:0]  voted_vertex;
    logic [PartW-1:0] target_partition;
    logic             wants_move;
    logic             range_error;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic upd;   // input transaction: count neighbour, restart scan state
    logic step;  // one scan step over the counters
    logic emit;  // load result register, clear counters and error
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_last;
    logic scan_last;
  } status_t;

endpackage

FILE: rtl/core/nmpv_in_if.sv
interface nmpv_in_if import nmpv_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/nmpv_out_if.sv
interface nmpv_out_if import nmpv_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/nmpv_datapath.sv
module nmpv_datapath import nmpv_pkg::*; #(
  parameter int MAX_PARTITIONS = MaxPartitionsDef,
  parameter int COUNT_BITS     = CountBitsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cmd_t            cmd_i,
  output status_t         status_o,
  input  in_item_t        in_data_i,
  input  logic [PiuW-1:0] piu_i,
  output out_item_t       out_data_o
);

  localparam int IdxW = $clog2(MAX_PARTITIONS);
  localparam int CmpW = (IdxW > PiuW) ? IdxW : PiuW;
  localparam logic [IdxW-1:0] IdxLast = IdxW'(MAX_PARTITIONS - 1);

  logic [COUNT_BITS-1:0] cnt_q [MAX_PARTITIONS];
  logic                  err_q;
  logic [VidW-1:0]       vid_q;
  logic [PartW-1:0]      own_q;
  logic [IdxW-1:0]       idx_q;
  logic [COUNT_BITS-1:0] max_q;
  logic [IdxW-1:0]       first_q;
  logic [COUNT_BITS-1:0] own_cnt_q;
  out_item_t             out_q;

  logic                  nb_ok;
  logic                  own_in_ok;
  logic                  idx_ok;
  logic [COUNT_BITS-1:0] cur_cnt;
  logic                  own_ok;
  logic                  keep_own;
  logic [PartW-1:0]      target;

  function automatic logic part_ok(input logic [PartW-1:0] p, input logic [PiuW-1:0] piu);
    return (CmpW'(p) < CmpW'(piu)) && (32'(p) < 32'(MAX_PARTITIONS));
  endfunction

  assign nb_ok     = part_ok(in_data_i.neighbor_partition, piu_i);
  assign own_in_ok = part_ok(in_data_i.own_partition, piu_i);
  assign idx_ok    = CmpW'(idx_q) < CmpW'(piu_i);
  assign cur_cnt   = cnt_q[idx_q];

  assign status_o.in_last   = in_data_i.last_of_vertex;
  assign status_o.scan_last = (idx_q == IdxLast);

  // one saturating counter per partition
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_PARTITIONS; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (cmd_i.emit) begin
      for (int i = 0; i < MAX_PARTITIONS; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (cmd_i.upd && in_data_i.has_neighbor && nb_ok) begin
      for (int i = 0; i < MAX_PARTITIONS; i++) begin
        if ((CmpW'(in_data_i.neighbor_partition) == CmpW'(i)) && (cnt_q[i] != '1)) begin
          cnt_q[i] <= cnt_q[i] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q <= 1'b0;
    end else if (cmd_i.emit) begin
      err_q <= 1'b0;
    end else if (cmd_i.upd && (!own_in_ok || (in_data_i.has_neighbor && !nb_ok))) begin
      err_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.upd) begin
      idx_q <= '0;
    end else if (cmd_i.step) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  // scan keeps the running maximum, its lowest index and the own count
  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) begin
      vid_q     <= in_data_i.vtx_id;
      own_q     <= in_data_i.own_partition;
      max_q     <= '0;
      first_q   <= '0;
      own_cnt_q <= '0;
    end else if (cmd_i.step && idx_ok) begin
      if (cur_cnt > max_q) begin
        max_q   <= cur_cnt;
        first_q <= idx_q;
      end
      if (CmpW'(idx_q) == CmpW'(own_q)) begin
        own_cnt_q <= cur_cnt;
      end
    end
  end

  // own wins when it holds the maximum, or when nothing was counted
  assign own_ok   = part_ok(own_q, piu_i);
  assign keep_own = (own_ok && (own_cnt_q == max_q)) || (max_q == '0);
  assign target   = keep_own ? own_q : PartW'(first_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.voted_vertex     <= vid_q;
      out_q.target_partition <= target;
      out_q.wants_move       <= (target != own_q);
      out_q.range_error      <= err_q;
    end
  end

  assign out_data_o = out_q;

  a_err_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> !err_q)
    else $error("run error not cleared after vote");

endmodule

FILE: rtl/core/nmpv_ctrl.sv
module nmpv_ctrl import nmpv_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam logic [1:0] StAccept = 2'd0;
  localparam logic [1:0] StScan   = 2'd1;
  localparam logic [1:0] StEmit   = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StAccept);

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      StAccept: begin
        cmd_o.upd = in_valid_i;
        if (in_valid_i && status_i.in_last) begin
          state_d = StScan;
        end
      end
      StScan: begin
        cmd_o.step = 1'b1;
        if (status_i.scan_last) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        // wait here while the previous result is still held
        if (out_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = StAccept;
        end
      end
      default: begin
        state_d = StAccept;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StAccept;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_last_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.upd && status_i.in_last) |=> (state_q == StScan))
    else $error("last transaction of a run did not start the scan");

  a_scan_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StScan) && !status_i.scan_last) |=> (state_q == StScan))
    else $error("scan left before the final counter");

  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> out_valid_q)
    else $error("result loaded without valid");

endmodule

FILE: rtl/core/neighbor_majority_partition_vote.sv
// result: after the last transaction of a run, a counter scan reads one partition counter per
//   cycle, then the vote is loaded into the result register
// throughput: one transaction per cycle inside a run; after the last transaction of a run
//   the input is held through the counter scan and until the result register is free
// reset: asynchronous, active low; counters and run error cleared, partitions_in_use = 16
module neighbor_majority_partition_vote import nmpv_pkg::*; #(
  parameter int MAX_PARTITIONS = MaxPartitionsDef,
  parameter int COUNT_BITS     = CountBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  nmpv_in_if.sink             in_i,
  nmpv_out_if.source          out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  logic [PiuW-1:0] piu_q;
  logic            reg_sel;
  cmd_t            cmd;
  status_t         status;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == RegIdxPiu);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      piu_q <= PiuReset;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      piu_q <= pwdata[PiuW-1:0];
    end
  end

  assign prdata = reg_sel ? ApbDataW'(piu_q) : '0;

  nmpv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  nmpv_datapath #(
    .MAX_PARTITIONS (MAX_PARTITIONS),
    .COUNT_BITS     (COUNT_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_data_i  (in_i.data),
    .piu_i      (piu_q),
    .out_data_o (out_o.data)
  );

endmodule
